// ===== hw/rtl/vmd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vmd_pkg
// shared types, register codes and the quarter-wave sine generator
// ----------------------------------------------------------------------------
package vmd_pkg;

	localparam logic [63:0] HALF_PI_Q28 = 64'd421657428;

	typedef enum logic [2:0] {
		REG_PHASE_STEP = 3'd0,
		REG_DEPTH      = 3'd1,
		REG_WET_MIX    = 3'd2,
		REG_DRY_MIX    = 3'd3,
		REG_CH_ENABLE  = 3'd4
	} vmd_reg_e;

	typedef struct packed {
		logic [23:0] phase_step;
		logic [16:0] depth;
		logic [15:0] wet_mix;
		logic [15:0] dry_mix;
		logic [7:0]  channel_enable;
	} vmd_cfg_t;

	// one queued input beat, classified
	typedef struct packed {
		logic               en;
		logic [2:0]         channel;
		logic signed [15:0] sample;
	} vmd_item_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LFO,
		ST_POS,
		ST_ADDR,
		ST_INTERP,
		ST_MIX
	} vmd_state_t;

	// taylor series to x^13 in q4.28, rounded to q1.16
	function automatic logic [16:0] vmd_qsine(input logic [63:0] x);
		logic [63:0] x2;
		logic [63:0] term;
		logic signed [63:0] sum;
		x2 = (x * x) >> 28;
		term = x;
		sum = signed'(x);
		for (int n = 1; n <= 6; n++) begin
			term = (term * x2) >> 28;
			case (n)
				1: term = term / 64'd6;
				2: term = term / 64'd20;
				3: term = term / 64'd42;
				4: term = term / 64'd72;
				5: term = term / 64'd110;
				default: term = term / 64'd156;
			endcase
			if (n[0])
				sum = sum - signed'(term);
			else
				sum = sum + signed'(term);
		end
		if (sum < 0)
			sum = 0;
		sum = signed'((unsigned'(sum) + 64'd2048) >> 12);
		if (sum > 65536)
			sum = 65536;
		return sum[16:0];
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/vmd_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vmd_front
// accepts input beats, marks them enabled or pass-through, two-entry queue
// ----------------------------------------------------------------------------
module vmd_front #(
	parameter int CHANNELS = 8
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire logic                hold,
	input  wire logic [2:0]          channel,
	input  wire logic signed [15:0]  sample_in,
	input  wire logic [7:0]          channel_enable,
	output      logic                full,
	output      logic                item_valid,
	output      vmd_pkg::vmd_item_t  item,
	input  wire logic                item_pop
);
	import vmd_pkg::*;

	vmd_item_t  slot_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       do_push, do_pop;
	vmd_item_t  new_item;

	always_comb begin
		new_item.channel = channel;
		new_item.sample  = sample_in;
		new_item.en      = ({1'b0, channel} < 4'(CHANNELS)) && channel_enable[channel];
	end

	assign full       = hold || (cnt_q == 2'd2);
	assign do_push    = push && !full;
	assign do_pop     = item_pop && (cnt_q != 2'd0);
	assign item_valid = (cnt_q != 2'd0);
	assign item       = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_q] <= new_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push)
				wr_q <= !wr_q;
			if (do_pop)
				rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/vmd_outq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vmd_outq
// two-entry result queue between the datapath and the result port
// ----------------------------------------------------------------------------
module vmd_outq (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               wr,
	input  wire logic signed [15:0] wr_data,
	output      logic               q_full,
	output      logic               empty,
	input  wire logic               pop,
	output      logic signed [15:0] sample_out
);
	logic signed [15:0] slot_q [2];
	logic               wr_q, rd_q;
	logic [1:0]         cnt_q;
	logic               do_pop;

	assign q_full     = (cnt_q == 2'd2);
	assign empty      = (cnt_q == 2'd0);
	assign do_pop     = pop && !empty;
	assign sample_out = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (wr)
			slot_q[wr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr)
				wr_q <= !wr_q;
			if (do_pop)
				rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(do_pop);
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/vmd_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vmd_back
// lfo, delay store, interpolation and mix sequencer
// ----------------------------------------------------------------------------
module vmd_back #(
	parameter int BUFFER_FRAMES = 241,
	parameter int CHANNELS      = 8,
	parameter int SINE_ENTRIES  = 256
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire vmd_pkg::vmd_cfg_t  cfg,
	input  wire logic               item_valid,
	input  wire vmd_pkg::vmd_item_t item,
	output      logic               item_pop,
	output      logic               clearing,
	input  wire logic               out_full,
	output      logic               out_wr,
	output      logic signed [15:0] out_data
);
	import vmd_pkg::*;

	localparam int QUARTER = SINE_ENTRIES / 4;
	localparam int IW      = $clog2(4 * QUARTER);
	localparam int TW      = $clog2(QUARTER + 1);
	localparam int PW      = (BUFFER_FRAMES > 2) ? $clog2(BUFFER_FRAMES) : 1;
	localparam int CW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int DEPTH   = CHANNELS * BUFFER_FRAMES;
	localparam int AW      = $clog2(DEPTH);
	localparam int LW      = 17 + PW;

	// quarter-wave table, built at elaboration
	logic [16:0] sine_tab [QUARTER + 1];
	for (genvar j = 0; j <= QUARTER; j++) begin : g_tab
		localparam logic [63:0] XJ = (64'(j) * HALF_PI_Q28) / QUARTER;
		localparam logic [16:0] SV = vmd_qsine(XJ);
		assign sine_tab[j] = SV;
	end

	logic signed [15:0] mem [DEPTH];

	vmd_state_t state_q, state_d;
	logic [AW-1:0]      clr_q;
	logic [23:0]        phase_q [CHANNELS];
	logic [PW-1:0]      wp_q [CHANNELS];

	logic [CW-1:0]      ch_s1;
	logic signed [15:0] x_s1;
	logic [PW-1:0]      w_s1;
	logic signed [17:0] sin_s1;
	logic [LW-1:0]      lfo_s2;
	logic [PW:0]        r1_s3;
	logic [15:0]        frac_s3;
	logic signed [15:0] rd_a_s4, rd_b_s4;
	logic signed [15:0] wet_s5;

	// sine lookup
	logic [CW-1:0]      ch_in;
	logic [23:0]        ph;
	logic [IW-1:0]      idx;
	logic [1:0]         quad;
	logic [IW-1:0]      rem;
	logic [TW-1:0]      tix;
	logic [16:0]        tval;
	logic signed [17:0] sin_d;

	assign ch_in = item.channel[CW-1:0];
	assign ph    = phase_q[ch_in];

	always_comb begin
		idx = IW'((37'(ph) * 37'(4 * QUARTER)) >> 24);
		if (idx >= IW'(3 * QUARTER)) begin
			quad = 2'd3;
			rem  = idx - IW'(3 * QUARTER);
		end else if (idx >= IW'(2 * QUARTER)) begin
			quad = 2'd2;
			rem  = idx - IW'(2 * QUARTER);
		end else if (idx >= IW'(QUARTER)) begin
			quad = 2'd1;
			rem  = idx - IW'(QUARTER);
		end else begin
			quad = 2'd0;
			rem  = idx;
		end
		if (quad[0])
			tix = TW'(QUARTER) - TW'(rem);
		else
			tix = TW'(rem);
		tval  = sine_tab[tix];
		sin_d = quad[1] ? -signed'({1'b0, tval}) : signed'({1'b0, tval});
	end

	// lfo scaling and read position
	logic [16:0]         dcl;
	logic [LW+16:0]      prod;
	logic [PW:0]         offs;
	logic [PW:0]         r1_sum;
	logic [PW:0]         r1_d;
	logic [PW:0]         r2_d;
	logic [AW-1:0]       base;
	logic [AW-1:0]       addr_a, addr_b, addr_w;

	assign dcl  = (cfg.depth > 17'd65536) ? 17'd65536 : cfg.depth;
	assign prod = (LW+17)'(lfo_s2) * (LW+17)'(dcl);

	always_comb begin
		offs = (PW+1)'(prod >> 32);
		if (offs >= (PW+1)'(BUFFER_FRAMES))
			offs = (PW+1)'(BUFFER_FRAMES - 1);
		r1_sum = (PW+1)'(w_s1) + offs;
		r1_d   = (r1_sum >= (PW+1)'(BUFFER_FRAMES)) ?
			r1_sum - (PW+1)'(BUFFER_FRAMES) : r1_sum;
		r2_d   = (r1_s3 + 1'b1 >= (PW+1)'(BUFFER_FRAMES)) ?
			(PW+1)'(0) : r1_s3 + 1'b1;
		base   = AW'(32'(ch_s1) * BUFFER_FRAMES);
		addr_a = base + AW'(r1_s3);
		addr_b = base + AW'(r2_d);
		addr_w = base + AW'(w_s1);
	end

	// interpolation and mix
	logic [15:0]         ua, ub;
	logic [32:0]         interp;
	logic signed [33:0]  mix_sum;
	logic signed [33:0]  mix_rnd;
	logic signed [18:0]  y;
	logic signed [15:0]  y_sat;

	always_comb begin
		ua      = {~rd_a_s4[15], rd_a_s4[14:0]};
		ub      = {~rd_b_s4[15], rd_b_s4[14:0]};
		interp  = 33'(ua) * 33'(17'd65536 - 17'(frac_s3)) + 33'(ub) * 33'(frac_s3);
		mix_sum = 34'(x_s1) * 34'(signed'({1'b0, cfg.dry_mix}))
			+ 34'(wet_s5) * 34'(signed'({1'b0, cfg.wet_mix}));
		mix_rnd = mix_sum + 34'sd16384;
		y       = 19'(mix_rnd >>> 15);
		if (y > 19'sd32767)
			y_sat = 16'sh7fff;
		else if (y < -19'sd32768)
			y_sat = 16'sh8000;
		else
			y_sat = y[15:0];
	end

	// sequencer
	logic mem_we;
	logic [AW-1:0] mem_wa;
	logic signed [15:0] mem_wd;

	always_comb begin
		state_d  = state_q;
		item_pop = 1'b0;
		out_wr   = 1'b0;
		out_data = y_sat;
		mem_we   = 1'b0;
		mem_wa   = addr_w;
		mem_wd   = x_s1;
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = clr_q;
				mem_wd = '0;
				if (clr_q == AW'(DEPTH - 1))
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (item_valid) begin
					if (!item.en) begin
						if (!out_full) begin
							item_pop = 1'b1;
							out_wr   = 1'b1;
							out_data = item.sample;
						end
					end else begin
						item_pop = 1'b1;
						state_d  = ST_LFO;
					end
				end
			end
			ST_LFO:    state_d = ST_POS;
			ST_POS:    state_d = ST_ADDR;
			ST_ADDR:   state_d = ST_INTERP;
			ST_INTERP: state_d = ST_MIX;
			ST_MIX: begin
				if (!out_full) begin
					out_wr  = 1'b1;
					mem_we  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign clearing = (state_q == ST_CLEAR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			for (int c = 0; c < CHANNELS; c++) begin
				phase_q[c] <= '0;
				wp_q[c]    <= '0;
			end
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR)
				clr_q <= clr_q + 1'b1;
			if (state_q == ST_IDLE && item_valid && item.en)
				phase_q[ch_in] <= ph + cfg.phase_step;
			if (state_q == ST_MIX && !out_full)
				wp_q[ch_s1] <= (w_s1 == PW'(BUFFER_FRAMES - 1)) ? '0 : w_s1 + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			ch_s1  <= ch_in;
			x_s1   <= item.sample;
			w_s1   <= wp_q[ch_in];
			sin_s1 <= sin_d;
		end
		if (state_q == ST_LFO)
			lfo_s2 <= LW'(((32'(sin_s1) + 32'sd65536) * 32'(BUFFER_FRAMES - 1)) >> 1);
		if (state_q == ST_POS) begin
			r1_s3   <= r1_d;
			frac_s3 <= prod[31:16];
		end
		if (state_q == ST_INTERP)
			wet_s5 <= {~interp[31], interp[30:16]};
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		if (state_q == ST_ADDR) begin
			rd_a_s4 <= mem[addr_a];
			rd_b_s4 <= mem[addr_b];
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/vibrato_modulated_delay.sv =====
`default_nettype none
// flow: pass-through beats go from the front queue to the result queue, one
// per cycle while the sequencer is idle and the result queue has room; an
// enabled-channel beat passes the LFO, POS, ADDR, INTERP and MIX states of
// the single lfo/interpolation/mix sequencer, which takes no new beat until
// MIX, waiting on a full result queue, writes it. reset: registers take their
// defaults at once, then a clearing pass zeroes the store while full is held
// ----------------------------------------------------------------------------
// vibrato_modulated_delay
// sine-lfo modulated delay line with per-channel store, phase and pointer
// ----------------------------------------------------------------------------
module vibrato_modulated_delay #(
	parameter int BUFFER_FRAMES = 241,
	parameter int CHANNELS      = 8,
	parameter int SINE_ENTRIES  = 256
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// input side
	input  wire logic               push,
	output      logic               full,
	input  wire logic [2:0]         channel,
	input  wire logic signed [15:0] sample_in,
	// result side
	output      logic               empty,
	input  wire logic               pop,
	output      logic signed [15:0] sample_out,
	// configuration writes
	input  wire logic               wr_en,
	input  wire logic [2:0]         wr_index,
	input  wire logic [23:0]        wr_data
);
	import vmd_pkg::*;

	vmd_cfg_t  cfg_q;
	vmd_item_t item;
	logic      item_valid, item_pop;
	logic      clearing;
	logic      out_full, out_wr;
	logic signed [15:0] out_data;

	// configuration registers; write only while the block is quiet (unenforced)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.phase_step     <= 24'd350;
			cfg_q.depth          <= 17'd65536;
			cfg_q.wet_mix        <= 16'd32768;
			cfg_q.dry_mix        <= 16'd0;
			cfg_q.channel_enable <= 8'd0;
		end else if (wr_en) begin
			case (vmd_reg_e'(wr_index))
				REG_PHASE_STEP: cfg_q.phase_step     <= wr_data;
				REG_DEPTH:      cfg_q.depth          <= wr_data[16:0];
				REG_WET_MIX:    cfg_q.wet_mix        <= wr_data[15:0];
				REG_DRY_MIX:    cfg_q.dry_mix        <= wr_data[15:0];
				REG_CH_ENABLE:  cfg_q.channel_enable <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	// front end: takes beats and tags them enabled or pass-through;
	// held full while the delay store is being cleared
	vmd_front #(
		.CHANNELS(CHANNELS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.hold           (clearing),
		.channel        (channel),
		.sample_in      (sample_in),
		.channel_enable (cfg_q.channel_enable),
		.full           (full),
		.item_valid     (item_valid),
		.item           (item),
		.item_pop       (item_pop)
	);

	// back end: sine lookup, lfo scaling, two-tap read, interpolation, mix
	vmd_back #(
		.BUFFER_FRAMES (BUFFER_FRAMES),
		.CHANNELS      (CHANNELS),
		.SINE_ENTRIES  (SINE_ENTRIES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop),
		.clearing   (clearing),
		.out_full   (out_full),
		.out_wr     (out_wr),
		.out_data   (out_data)
	);

	// result queue parts the datapath from the consumer
	vmd_outq u_outq (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr         (out_wr),
		.wr_data    (out_data),
		.q_full     (out_full),
		.empty      (empty),
		.pop        (pop),
		.sample_out (sample_out)
	);

endmodule
`default_nettype wire
